FILE: design/cks_pkg.sv
// Shared types, constants and key compare for the composite key insertion sorter.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package cks_pkg;

  localparam int CAPACITY    = 64;
  localparam int MAX_RESULTS = 64;
  localparam int ID_W        = 16;
  localparam int CNT_W       = 8;
  localparam int RANK_W      = 16;
  localparam int ME_W        = 7;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [ME_W-1:0]   MAX_EMITTED_RESET = ME_W'(30);
  localparam logic [CFG_AW-1:0] REG_MAX_EMITTED   = CFG_AW'(0);
  localparam logic              KIND_LOAD         = 1'b0;
  localparam logic              KIND_FLUSH        = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [RANK_W-1:0] rank;
  } rec_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic clear;
    rec_t key;
  } cell_ctrl_t;

  function automatic logic beats(input rec_t a, input rec_t b);
    logic res;
    if (a.count != b.count) begin
      res = a.count > b.count;
    end else begin
      res = a.rank > b.rank;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/cks_in_if.sv
// Input channel: load or flush transactions with valid/ready handshake.
// Depends on cks_pkg for field widths.
`default_nettype none
interface cks_in_if;
  import cks_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   record_id;
  logic [CNT_W-1:0]  match_count;
  logic [RANK_W-1:0] rank;

  modport source (output valid, kind, record_id, match_count, rank, input ready);
  modport sink (input valid, kind, record_id, match_count, rank, output ready);
endinterface
`default_nettype wire

FILE: design/cks_out_if.sv
// Result channel: emitted records with valid/ready handshake.
// Depends on cks_pkg for field widths.
`default_nettype none
interface cks_out_if;
  import cks_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [CNT_W-1:0]  out_count;
  logic [RANK_W-1:0] out_rank;
  logic              last;

  modport source (output valid, out_id, out_count, out_rank, last, input ready);
  modport sink (input valid, out_id, out_count, out_rank, last, output ready);
endinterface
`default_nettype wire

FILE: design/cks_cell.sv
// One slot of the sorted chain: holds a record, inserts or shifts on load, shifts on pop.
// Depends on cks_pkg.
`default_nettype none
module cks_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cks_pkg::cell_ctrl_t ctrl,
  input  wire logic              left_ins,
  input  wire logic              left_valid,
  input  wire cks_pkg::rec_t     left_rec,
  input  wire logic              right_valid,
  input  wire cks_pkg::rec_t     right_rec,
  output logic                   ins,
  output logic                   valid,
  output cks_pkg::rec_t          rec
);
  import cks_pkg::*;

  logic valid_r, valid_nxt;
  rec_t rec_r, rec_nxt;

  assign ins   = !valid_r || beats(ctrl.key, rec_r);
  assign valid = valid_r;
  assign rec   = rec_r;

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.pop) begin
      valid_nxt = right_valid;
      rec_nxt   = right_rec;
    end else if (ctrl.load && ins) begin
      if (left_ins) begin
        valid_nxt = left_valid;
        rec_nxt   = left_rec;
      end else begin
        valid_nxt = 1'b1;
        rec_nxt   = ctrl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    rec_r <= rec_nxt;
  end
endmodule
`default_nettype wire

FILE: design/composite_key_insertion_sorter.sv
// Composite key insertion sorter: a chain of CAPACITY cells kept sorted best first.
// Load: one per cycle, in_ready stays high; the record is in place at the next edge, or dropped if the chain is full.
// Flush: one record per cycle from the head of the chain while out_ready is high, up to max_emitted
// and stopping at a zero count, then the chain is cleared; in_ready is low for the flush.
// Reset (rst_n low, synchronous): chain empty, max_emitted = 30, no result pending.
// Depends on cks_pkg, cks_in_if, cks_out_if and cks_cell.
`default_nettype none
module composite_key_insertion_sorter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cks_in_if.sink                           in_if,
  cks_out_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cks_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [cks_pkg::CFG_DW-1:0]  pwdata,
  output logic      [cks_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import cks_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [ME_W-1:0]    max_emitted_r;
  logic [EMIT_W-1:0]  emitted_r, emitted_nxt;
  logic               out_valid_r, out_valid_nxt;
  rec_t               out_rec_r, out_rec_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctrl_t ctrl;
  logic       ins_a   [CAPACITY];
  logic       valid_a [CAPACITY];
  rec_t       rec_a   [CAPACITY];

  logic              in_acc, full, can_out, head_ok, last_pick;
  logic [EMIT_W-1:0] limit;

  assign pready = 1'b1;
  assign prdata = CFG_DW'(max_emitted_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_emitted_r <= MAX_EMITTED_RESET;
    end else if (psel && penable && pwrite && paddr[CFG_AW-1] == REG_MAX_EMITTED[CFG_AW-1]) begin
      max_emitted_r <= pwdata[ME_W-1:0];
    end
  end

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign full        = valid_a[CAPACITY-1];
  assign can_out     = !out_valid_r || out_if.ready;
  assign limit       = (EMIT_W'(max_emitted_r) > EMIT_W'(MAX_RESULTS)) ?
                       EMIT_W'(MAX_RESULTS) : EMIT_W'(max_emitted_r);
  assign head_ok     = valid_a[0] && (rec_a[0].count != '0) && (emitted_r < limit);
  assign last_pick   = (emitted_r + EMIT_W'(1) == limit) || !valid_a[1] ||
                       (rec_a[1].count == '0);

  always_comb begin
    state_nxt     = state_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    ctrl.load     = 1'b0;
    ctrl.pop      = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.key.id    = in_if.record_id;
    ctrl.key.count = in_if.match_count;
    ctrl.key.rank  = in_if.rank;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.kind == KIND_FLUSH) begin
            state_nxt   = ST_FLUSH;
            emitted_nxt = '0;
          end else begin
            ctrl.load = !full;
          end
        end
      end
      ST_FLUSH: begin
        if (!head_ok) begin
          ctrl.clear = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (can_out) begin
          ctrl.pop      = 1'b1;
          out_valid_nxt = 1'b1;
          out_rec_nxt   = rec_a[0];
          out_last_nxt  = last_pick;
          emitted_nxt   = emitted_r + EMIT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_id    = out_rec_r.id;
  assign out_if.out_count = out_rec_r.count;
  assign out_if.out_rank  = out_rec_r.rank;
  assign out_if.last      = out_last_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic l_ins, l_valid, r_valid;
    rec_t l_rec, r_rec;

    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_rec   = '0;
    end else begin : g_body
      assign l_ins   = ins_a[i-1];
      assign l_valid = valid_a[i-1];
      assign l_rec   = rec_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_rec   = '0;
    end else begin : g_mid
      assign r_valid = valid_a[i+1];
      assign r_rec   = rec_a[i+1];
    end

    cks_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_ins    (l_ins),
      .left_valid  (l_valid),
      .left_rec    (l_rec),
      .right_valid (r_valid),
      .right_rec   (r_rec),
      .ins         (ins_a[i]),
      .valid       (valid_a[i]),
      .rec         (rec_a[i])
    );
  end
endmodule
`default_nettype wire

FILE: tb/composite_key_insertion_sorter_test.sv
`timescale 1ns / 1ps
// Testbench for composite_key_insertion_sorter: a directed table, then random load/flush batches.
// Emitted records are checked against a sorted shadow store kept here.
// Depends on cks_pkg, cks_in_if, cks_out_if and the block itself.
module composite_key_insertion_sorter_test;
  import cks_pkg::*;

  localparam int RANDOM_ITEMS   = 236;
  localparam int QUIET_TAIL     = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DIR_ROWS       = 24;
  localparam logic [CFG_AW-1:0] REG_UNMAPPED = CFG_AW'(4);

  typedef struct packed {
    rec_t rec;
    logic last;
  } emit_t;

  typedef struct packed {
    logic              cfg;
    logic [CFG_AW-1:0] cfg_addr;
    logic [ME_W-1:0]   cfg_val;
    logic              kind;
    rec_t              rec;
    logic              typed;
    logic              typed_one;
    rec_t              typed_rec;
  } dir_row_t;

  localparam rec_t NOREC = '0;

  // cfg, addr, value, kind, record, typed, one record expected, expected record
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h1234, 8'h56, 16'h789A}, 1'b1, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'hFFFF, 8'hFF, 16'hFFFF}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b1, 1'b1,
      '{16'hFFFF, 8'hFF, 16'hFFFF}},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0000, 8'h00, 16'h0000}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0001, 8'h05, 16'h0064}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0002, 8'h05, 16'h0064}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0003, 8'h05, 16'h00C8}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0004, 8'h06, 16'h0000}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0005, 8'h00, 16'hFFFF}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0006, 8'hFF, 16'h0000}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b0, 1'b0, NOREC},
    '{1'b1, REG_MAX_EMITTED, 7'd1, KIND_LOAD, '{16'h0007, 8'h0A, 16'h000A}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0008, 8'h14, 16'h0014}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b1, 1'b1,
      '{16'h0008, 8'h14, 16'h0014}},
    '{1'b1, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h0009, 8'h01, 16'h0001}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b1, 1'b0, NOREC},
    '{1'b1, REG_MAX_EMITTED, 7'd127, KIND_LOAD, '{16'hAAAA, 8'h80, 16'h8000}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'h5555, 8'h80, 16'h8000}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'hFFFF, 8'h01, 16'hFFFF}, 1'b0, 1'b0, NOREC},
    '{1'b1, REG_UNMAPPED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b0, 1'b0, NOREC},
    '{1'b1, REG_MAX_EMITTED, 7'd64, KIND_LOAD, '{16'h0000, 8'hFF, 16'hFFFF}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_LOAD, '{16'hFFFF, 8'hFF, 16'hFFFF}, 1'b0, 1'b0, NOREC},
    '{1'b0, REG_MAX_EMITTED, 7'd0, KIND_FLUSH, '{16'h0000, 8'h00, 16'h0000}, 1'b0, 1'b0, NOREC}
  };

  logic [ME_W-1:0] limit_plan [5] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd45};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cks_in_if  in_ch ();
  cks_out_if out_ch ();

  rec_t            ranked_store [$];
  emit_t           due_records [$];
  logic [ME_W-1:0] emit_limit;
  logic            row_typed;
  logic            row_typed_one;
  rec_t            row_typed_rec;
  int              quiet_cycles = 0;
  int              fail_count = 0;
  int              hold_requests = 0;
  int              hold_served = 0;
  int              hold_left = 0;
  int              sink_gap = 0;
  bit              sink_stalls = 1'b1;
  bit              src_idle = 1'b1;

  composite_key_insertion_sorter u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function automatic logic ranks_ahead(rec_t a, rec_t b);
    return {a.count, a.rank} > {b.count, b.rank};
  endfunction

  function automatic void insert_record(rec_t r);
    int pos;
    pos = 0;
    if (ranked_store.size() < CAPACITY) begin
      while (pos < ranked_store.size() && !ranks_ahead(r, ranked_store[pos])) pos++;
      ranked_store.insert(pos, r);
    end
  endfunction

  function automatic void flush_records();
    int lim;
    int n;
    lim = (int'(emit_limit) > MAX_RESULTS) ? MAX_RESULTS : int'(emit_limit);
    n = 0;
    while (n < lim && n < ranked_store.size() && ranked_store[n].count != '0) n++;
    for (int k = 0; k < n; k++) due_records.push_back(emit_t'{ranked_store[k], k == n - 1});
    ranked_store.delete();
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  function automatic rec_t random_record();
    rec_t r;
    r.id = 16'($urandom);
    case ($urandom_range(0, 3))
      0: r.count = 8'($urandom_range(0, 3));
      1: r.count = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: r.count = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: r.rank = 16'($urandom_range(0, 3));
      1: r.rank = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: r.rank = 16'($urandom);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    emit_t want;
    int    keep;
    if (!rst_n) begin
      ranked_store.delete();
      due_records.delete();
      emit_limit = MAX_EMITTED_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (psel && penable && pwrite && pready) begin
        quiet_cycles = 0;
        if (paddr == REG_MAX_EMITTED) emit_limit = pwdata[ME_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        if (in_ch.kind == KIND_LOAD) begin
          insert_record(rec_t'{in_ch.record_id, in_ch.match_count, in_ch.rank});
        end else begin
          keep = due_records.size();
          flush_records();
          if (row_typed) begin
            while (due_records.size() > keep) void'(due_records.pop_back());
            if (row_typed_one) due_records.push_back(emit_t'{row_typed_rec, 1'b1});
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (due_records.size() == 0) begin
          $display("%0t: record mismatch, expected none, actual %0h %0h %0h %0b",
                   $time, out_ch.out_id, out_ch.out_count, out_ch.out_rank, out_ch.last);
          fail_count++;
        end else begin
          want = due_records.pop_front();
          check_field("out_id", 32'(want.rec.id), 32'(out_ch.out_id));
          check_field("out_count", 32'(want.rec.count), 32'(out_ch.out_count));
          check_field("out_rank", 32'(want.rec.rank), 32'(out_ch.out_rank));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_stalls && sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 10);
    end
  end

  task automatic send_txn(input logic kind, input rec_t r, input logic typed, input logic one,
                          input rec_t tr);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.record_id <= r.id;
    in_ch.match_count <= r.count;
    in_ch.rank <= r.rank;
    row_typed <= typed;
    row_typed_one <= one;
    row_typed_rec <= tr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic source_gap();
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_records.size() != 0 || !in_ch.ready);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [ME_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_emit_limit();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_MAX_EMITTED;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(emit_limit)) begin
      $display("%0t: max_emitted readback mismatch, expected %0h, actual %0h",
               $time, emit_limit, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    wait (rst_n === 1'b1);
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    dir_row_t        row;
    int              sent;
    int              batch;
    int              loads;
    int              plan_idx;
    logic [ME_W-1:0] next_limit;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.record_id = '0;
    in_ch.match_count = '0;
    in_ch.rank = '0;
    out_ch.ready = 1'b0;
    row_typed = 1'b0;
    row_typed_one = 1'b0;
    row_typed_rec = NOREC;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_emit_limit();

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.cfg) begin
        drain();
        cfg_write(row.cfg_addr, row.cfg_val);
        check_emit_limit();
      end
      send_txn(row.kind, row.rec, row.typed, row.typed_one, row.typed_rec);
      source_gap();
    end

    sent = 0;
    batch = 0;
    plan_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      if (batch % 4 == 0 && sent < RANDOM_ITEMS - QUIET_TAIL) begin
        drain();
        next_limit = (plan_idx < 5) ? limit_plan[plan_idx] : ME_W'($urandom_range(1, 127));
        plan_idx++;
        cfg_write(REG_MAX_EMITTED, next_limit);
        check_emit_limit();
        src_idle = $urandom_range(0, 3) != 0;
        sink_stalls = $urandom_range(0, 3) != 0;
      end
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle = 1'b0;
        sink_stalls = 1'b0;
      end
      // overfill the store while the receiver holds off
      if (batch == 2) begin
        loads = 70;
        hold_requests++;
      end else if ($urandom_range(0, 9) == 0) begin
        loads = $urandom_range(60, 70);
      end else begin
        loads = $urandom_range(0, 12);
      end
      if (loads > RANDOM_ITEMS - sent - 1) loads = RANDOM_ITEMS - sent - 1;
      repeat (loads) begin
        send_txn(KIND_LOAD, random_record(), 1'b0, 1'b0, NOREC);
        source_gap();
        sent++;
      end
      send_txn(KIND_FLUSH, random_record(), 1'b0, 1'b0, NOREC);
      source_gap();
      sent++;
      batch++;
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
